### rtl/hhrg_pkg.sv
// Shared types and constants for the heater hysteresis regulator with rate guard.
// No dependencies; imported by the top level.
package hhrg_pkg;

  // Field widths
  localparam int unsigned TempW  = 17;
  localparam int unsigned ElapW  = 16;
  localparam int unsigned RateW  = 24;
  localparam int unsigned LimW   = 17;
  localparam int unsigned ErrW   = 8;
  localparam int unsigned SumW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 17;

  // Wide temperature compare width (room for the offsets below)
  localparam int unsigned CmpW = TempW + 2;

  // Rate datapath: |diff| * 1000 fits in 27 bits, divisor is elapsed + 1
  localparam int unsigned MagW   = TempW;
  localparam int unsigned QuoW   = 27;
  localparam int unsigned DivW   = ElapW + 1;
  localparam int unsigned StepW  = $clog2(QuoW);

  // Temperature offsets in hundredths of a degree
  localparam logic signed [CmpW-1:0] Hyst      = CmpW'(30);
  localparam logic signed [CmpW-1:0] BandLow   = CmpW'(100);
  localparam logic signed [CmpW-1:0] BandHigh  = CmpW'(300);
  localparam logic signed [CmpW-1:0] OverMargin = CmpW'(500);
  localparam logic [9:0]             RateScale = 10'd1000;

  // Register reset values
  localparam logic signed [TempW-1:0] TargetRst = TempW'(6000);
  localparam logic signed [TempW-1:0] MaxRst    = TempW'(8000);
  localparam logic [LimW-1:0]         RateMinRst = LimW'(1);
  localparam logic [LimW-1:0]         RateMaxRst = LimW'(500);
  localparam logic [ErrW-1:0]         ErrLimRst  = ErrW'(10);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET   = 3'd0,
    CFG_MAX      = 3'd1,
    CFG_RATE_MIN = 3'd2,
    CFG_RATE_MAX = 3'd3,
    CFG_ERR_LIM  = 3'd4,
    CFG_SENSOR   = 3'd5
  } cfg_idx_e;

endpackage

### rtl/heater_hysteresis_with_rate_guard.sv
// Top level of the heater regulator: hysteresis relay, over-temperature cutoff,
// serial rise-rate divider and rate guard. Depends on hhrg_pkg.

// One transaction per temperature sample, one result per sample. A sample with
// heating enabled and the sensor present goes from acceptance to result through
// setup, a scaling multiply, a one-bit-per-cycle restoring divider for the rise
// rate, saturation, accumulation and the relay update. A sample that skips
// rate tracking goes straight to the relay update. One sample is in work at a
// time; the result register lets the next sample be taken while a result still
// waits downstream. Configuration writes are taken on any cycle with cfg_we_i.
module heater_hysteresis_with_rate_guard (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [hhrg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [hhrg_pkg::CfgW-1:0]        cfg_data_i,
  // sample channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [hhrg_pkg::TempW-1:0] temperature_i,
  input  logic [hhrg_pkg::ElapW-1:0]       elapsed_ms_i,
  input  logic                             heating_enable_i,
  input  logic                             restart_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             relay_on_o,
  output logic                             at_target_o,
  output logic                             overflow_o,
  output logic signed [hhrg_pkg::RateW-1:0] rise_rate_o,
  output logic [hhrg_pkg::ErrW-1:0]        errors_remaining_o,
  output logic signed [hhrg_pkg::SumW-1:0] rate_sum_o,
  output logic [hhrg_pkg::CntW-1:0]        rate_count_o
);
  import hhrg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_ACC,
    ST_FINISH
  } state_e;

  // Configuration registers
  logic signed [TempW-1:0] target_q, max_q;
  logic [LimW-1:0]         rate_min_q, rate_max_q;
  logic [ErrW-1:0]         err_lim_q;
  logic                    sensor_q;

  // Regulator state
  logic signed [TempW-1:0] prev_q;
  logic signed [RateW-1:0] rate_q;
  logic                    relay_q, band_q, latch_q;
  logic [ErrW-1:0]         err_cnt_q;
  logic signed [SumW-1:0]  sum_q;
  logic [CntW-1:0]         cnt_q;

  // Sample and datapath registers
  state_e                  state_q;
  logic signed [TempW-1:0] temp_q;
  logic [ElapW-1:0]        elap_q;
  logic                    heat_q;
  logic                    neg_q;
  logic [MagW-1:0]         mag_q;
  logic [QuoW-1:0]         num_q;
  logic [DivW-1:0]         rem_q;
  logic [DivW-1:0]         div_q;
  logic [StepW-1:0]        step_q;

  // Result register
  logic                    out_valid_q;
  logic                    out_relay_q, out_band_q, out_latch_q;
  logic signed [RateW-1:0] out_rate_q;
  logic [ErrW-1:0]         out_err_q;
  logic signed [SumW-1:0]  out_sum_q;
  logic [CntW-1:0]         out_cnt_q;

  logic                    in_acc;
  logic                    out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Temperature difference
  logic signed [TempW:0] diff;
  assign diff = {temp_q[TempW-1], temp_q} - {prev_q[TempW-1], prev_q};

  // Scale magnitude by 1000
  logic [QuoW-1:0] prod;
  assign prod = QuoW'(mag_q) * QuoW'(RateScale);

  // One restoring divide step
  logic [DivW:0]   trial;
  logic [DivW:0]   shifted;
  logic            q_bit;
  assign shifted = {rem_q, num_q[QuoW-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign q_bit   = !trial[DivW];

  // Saturate the signed quotient to the rate range
  logic signed [RateW-1:0] rate_sat;
  always_comb begin
    if (num_q[QuoW-1:RateW-1] != '0) begin
      rate_sat = neg_q ? {1'b1, {(RateW-1){1'b0}}} : {1'b0, {(RateW-1){1'b1}}};
    end else if (neg_q) begin
      rate_sat = -$signed({1'b0, num_q[RateW-2:0]});
    end else begin
      rate_sat = $signed({1'b0, num_q[RateW-2:0]});
    end
  end

  // Saturating accumulation of nonzero rates
  logic signed [SumW:0]    sum_ext;
  logic signed [SumW-1:0]  sum_sat;
  assign sum_ext = {sum_q[SumW-1], sum_q} + (SumW+1)'(rate_q);
  always_comb begin
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  // Relay, band and guard decisions
  logic signed [CmpW-1:0] t_w, tgt_w, max_w;
  logic                   relay_d, band_d, latch_d;
  logic [ErrW-1:0]        err_d;
  logic                   rate_pos, rate_bad, over_temp;
  assign t_w   = CmpW'(temp_q);
  assign tgt_w = CmpW'(target_q);
  assign max_w = CmpW'(max_q);
  assign over_temp = t_w > (max_w + OverMargin);
  assign rate_pos  = !rate_q[RateW-1] && (rate_q != '0);
  assign rate_bad  = (rate_q[RateW-2:0] < (RateW-1)'(rate_min_q)) ||
                     (rate_q[RateW-2:0] > (RateW-1)'(rate_max_q));

  always_comb begin
    relay_d = relay_q;
    band_d  = band_q;
    latch_d = latch_q;
    err_d   = err_cnt_q;
    if (heat_q) begin
      if (t_w <= tgt_w - Hyst) begin
        relay_d = 1'b1;
      end else begin
        band_d = (t_w >= tgt_w - BandLow) && (t_w < tgt_w + BandHigh);
        if (t_w >= tgt_w + Hyst) begin
          relay_d = 1'b0;
        end
      end
      if (over_temp) begin
        relay_d = 1'b0;
        latch_d = 1'b1;
      end else if (relay_d && rate_pos && rate_bad) begin
        if (err_cnt_q != '0) begin
          err_d = err_cnt_q - ErrW'(1);
        end
        if (err_d == '0) begin
          latch_d = 1'b1;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TargetRst;
      max_q      <= MaxRst;
      rate_min_q <= RateMinRst;
      rate_max_q <= RateMaxRst;
      err_lim_q  <= ErrLimRst;
      sensor_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET:   target_q   <= cfg_data_i;
        CFG_MAX:      max_q      <= cfg_data_i;
        CFG_RATE_MIN: rate_min_q <= cfg_data_i;
        CFG_RATE_MAX: rate_max_q <= cfg_data_i;
        CFG_ERR_LIM:  err_lim_q  <= cfg_data_i[ErrW-1:0];
        CFG_SENSOR:   sensor_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer, regulator state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      rate_q      <= '0;
      relay_q     <= 1'b0;
      band_q      <= 1'b0;
      latch_q     <= 1'b0;
      err_cnt_q   <= ErrLimRst;
      sum_q       <= '0;
      cnt_q       <= '0;
      temp_q      <= '0;
      elap_q      <= '0;
      heat_q      <= 1'b0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_relay_q <= 1'b0;
      out_band_q  <= 1'b0;
      out_latch_q <= 1'b0;
      out_rate_q  <= '0;
      out_err_q   <= '0;
      out_sum_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      // drop the result once taken, unless a new one is loaded now
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            temp_q <= temperature_i;
            elap_q <= elapsed_ms_i;
            heat_q <= heating_enable_i;
            if (restart_i) begin
              err_cnt_q <= err_lim_q;
              latch_q   <= 1'b0;
            end
            state_q <= (heating_enable_i && sensor_q) ? ST_DIFF : ST_FINISH;
          end
        end
        ST_DIFF: begin
          neg_q   <= diff[TempW];
          mag_q   <= diff[TempW] ? MagW'(-diff) : diff[MagW-1:0];
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          num_q   <= prod;
          rem_q   <= '0;
          div_q   <= {1'b0, elap_q} + DivW'(1);
          step_q  <= StepW'(QuoW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // shift in one quotient bit per cycle
          rem_q  <= q_bit ? trial[DivW-1:0] : shifted[DivW-1:0];
          num_q  <= {num_q[QuoW-2:0], q_bit};
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          rate_q  <= rate_sat;
          prev_q  <= temp_q;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (rate_q != '0) begin
            sum_q <= sum_sat;
            if (cnt_q != '1) begin
              cnt_q <= cnt_q + CntW'(1);
            end
          end
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold until the result register is free
          if (out_free) begin
            relay_q     <= relay_d;
            band_q      <= band_d;
            latch_q     <= latch_d;
            err_cnt_q   <= err_d;
            out_valid_q <= 1'b1;
            out_relay_q <= relay_d;
            out_band_q  <= band_d;
            out_latch_q <= latch_d;
            out_rate_q  <= rate_q;
            out_err_q   <= err_d;
            out_sum_q   <= sum_q;
            out_cnt_q   <= cnt_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign relay_on_o         = out_relay_q;
  assign at_target_o        = out_band_q;
  assign overflow_o         = out_latch_q;
  assign rise_rate_o        = out_rate_q;
  assign errors_remaining_o = out_err_q;
  assign rate_sum_o         = out_sum_q;
  assign rate_count_o       = out_cnt_q;

endmodule

### sim/tb.sv
// Self-checking testbench for heater_hysteresis_with_rate_guard: a directed
// table, then closed-loop heating ramps with noise, checked against a predictor.
// Depends on hhrg_pkg and the top level of the regulator.
`timescale 1ns / 100ps

module tb;
  import hhrg_pkg::*;

  localparam int     NumDirected   = 21;
  localparam int     NumPhases     = 8;
  localparam int     ItemsPerPhase = 192;
  localparam int     HoldPhase     = 4;
  localparam int     LongHold      = 400;
  localparam int     TailCycles    = 40;
  localparam longint HystC         = 30;
  localparam longint BandLoC       = 100;
  localparam longint BandHiC       = 300;
  localparam longint OverC         = 500;
  localparam longint ScaleC        = 1000;
  localparam longint RateHi        = 64'sd8388607;
  localparam longint RateLo        = -64'sd8388608;
  localparam longint SumHi         = 64'sd2147483647;
  localparam longint SumLo         = -64'sd2147483648;
  localparam longint TempHi        = 64'sd65535;
  localparam longint TempLo        = -64'sd65536;

  typedef enum int {RX_FREE, RX_RANDOM, RX_HEAVY, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [ElapW-1:0]        elapsed;
    logic                    heat;
    logic                    restart;
  } sample_t;

  typedef struct packed {
    logic                    relay;
    logic                    band;
    logic                    fault;
    logic signed [RateW-1:0] rate;
    logic [ErrW-1:0]         errs;
    logic signed [SumW-1:0]  sum;
    logic [CntW-1:0]         count;
  } result_t;

  typedef struct packed {
    sample_t smp;
    logic    typed;
    result_t want;
  } row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CfgW-1:0]         cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [TempW-1:0] temperature_i;
  logic [ElapW-1:0]        elapsed_ms_i;
  logic                    heating_enable_i;
  logic                    restart_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    relay_on_o;
  logic                    at_target_o;
  logic                    overflow_o;
  logic signed [RateW-1:0] rise_rate_o;
  logic [ErrW-1:0]         errors_remaining_o;
  logic signed [SumW-1:0]  rate_sum_o;
  logic [CntW-1:0]         rate_count_o;

  // Predictor configuration and state
  longint    cf_target, cf_max, cf_rmin, cf_rmax;
  int        cf_elim;
  bit        cf_sensor;
  longint    pv_temp, pv_rate, pv_sum;
  bit        pv_relay, pv_band, pv_fault;
  int        pv_errs;
  bit [31:0] pv_count;

  result_t   expected_results[$];
  row_t      dir_tbl [NumDirected];
  int        n_fail;
  rx_mode_e  rx_mode;
  int        hold_reqs;
  int        holds_done;
  int        hold_left;
  int        rx_tick;

  heater_hysteresis_with_rate_guard dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .temperature_i      (temperature_i),
    .elapsed_ms_i       (elapsed_ms_i),
    .heating_enable_i   (heating_enable_i),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .relay_on_o         (relay_on_o),
    .at_target_o        (at_target_o),
    .overflow_o         (overflow_o),
    .rise_rate_o        (rise_rate_o),
    .errors_remaining_o (errors_remaining_o),
    .rate_sum_o         (rate_sum_o),
    .rate_count_o       (rate_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #12000000;
    $display("FAILURE");
    $finish;
  end

  // Advance the regulator model by one sample and return the expected result
  function automatic result_t regulate_sample(input sample_t s);
    longint  t;
    longint  q;
    bit      chk;
    result_t res;
    t = longint'($signed(s.temp));
    if (s.restart) begin
      pv_errs  = cf_elim;
      pv_fault = 1'b0;
    end
    if (s.heat) begin
      chk = 1'b1;
      // track rise rate, sum and count only with a sensor fitted
      if (cf_sensor) begin
        q = ((t - pv_temp) * ScaleC) / (longint'(s.elapsed) + 1);
        if (q > RateHi) q = RateHi;
        if (q < RateLo) q = RateLo;
        pv_rate = q;
        pv_temp = t;
        if (pv_rate != 0) begin
          q = pv_sum + pv_rate;
          if (q > SumHi) q = SumHi;
          if (q < SumLo) q = SumLo;
          pv_sum = q;
          if (pv_count != 32'hFFFF_FFFF) pv_count++;
        end
      end
      // hysteresis relay; band flag holds while at or below target minus hysteresis
      if (t <= cf_target - HystC) begin
        pv_relay = 1'b1;
      end else begin
        pv_band = (t >= cf_target - BandLoC) && (t < cf_target + BandHiC);
        if (t >= cf_target + HystC) pv_relay = 1'b0;
      end
      // over-temperature cutoff skips the rate guard
      if (t > cf_max + OverC) begin
        pv_relay = 1'b0;
        pv_fault = 1'b1;
        chk      = 1'b0;
      end
      if (chk && pv_relay && pv_rate > 0 && (pv_rate < cf_rmin || pv_rate > cf_rmax)) begin
        if (pv_errs > 0) pv_errs--;
        if (pv_errs == 0) pv_fault = 1'b1;
      end
    end
    res.relay = pv_relay;
    res.band  = pv_band;
    res.fault = pv_fault;
    res.rate  = pv_rate[RateW-1:0];
    res.errs  = pv_errs[ErrW-1:0];
    res.sum   = pv_sum[SumW-1:0];
    res.count = pv_count;
    return res;
  endfunction

  // Offer one sample, hold it until accepted, then record its expected result
  task automatic send_sample(input sample_t smp, input bit typed, input result_t want);
    result_t predicted;
    in_valid_i       <= 1'b1;
    temperature_i    <= smp.temp;
    elapsed_ms_i     <= smp.elapsed;
    heating_enable_i <= smp.heat;
    restart_i        <= smp.restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = regulate_sample(smp);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; write enable stays high for back-to-back writes
  task automatic set_reg(input cfg_idx_e idx, input longint val);
    logic [CfgW-1:0] d;
    d = val[CfgW-1:0];
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_TARGET:   cf_target = longint'($signed(d));
      CFG_MAX:      cf_max    = longint'($signed(d));
      CFG_RATE_MIN: cf_rmin   = longint'(d);
      CFG_RATE_MAX: cf_rmax   = longint'(d);
      CFG_ERR_LIM:  cf_elim   = int'(d[ErrW-1:0]);
      CFG_SENSOR:   cf_sensor = d[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input longint tg, input longint mx, input longint rmn,
                               input longint rmx, input longint el, input longint sn);
    set_reg(CFG_TARGET, tg);
    set_reg(CFG_MAX, mx);
    set_reg(CFG_RATE_MIN, rmn);
    set_reg(CFG_RATE_MAX, rmx);
    set_reg(CFG_ERR_LIM, el);
    set_reg(CFG_SENSOR, sn);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare one field and report a mismatch
  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      n_fail++;
      $display("%0t ns: %s expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // Result monitor: match each accepted transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        n_fail++;
        $display("%0t ns: result transaction with no expectation, expected none, got one",
                 $time);
      end else begin
        want = expected_results.pop_front();
        check_field("relay_on", longint'(want.relay), longint'(relay_on_o));
        check_field("at_target", longint'(want.band), longint'(at_target_o));
        check_field("overflow", longint'(want.fault), longint'(overflow_o));
        check_field("rise_rate", longint'($signed(want.rate)), longint'($signed(rise_rate_o)));
        check_field("errors_remaining", longint'(want.errs), longint'(errors_remaining_o));
        check_field("rate_sum", longint'($signed(want.sum)), longint'($signed(rate_sum_o)));
        check_field("rate_count", longint'(want.count), longint'(rate_count_o));
      end
    end
  end

  // Receiver: stall pattern per phase, plus a long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_tick++;
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall_i <= 1'b0;
          RX_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
          RX_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
          default:   out_stall_i <= ((rx_tick % 11) < 4);
        endcase
      end
    end
  end

  // Sender: reset, directed table, then phases of random transactions
  initial begin : stimulus
    sample_t smp;
    longint  ramp_t;
    longint  tg, mx, rmn, rmx;
    int      kind, burst_left, g, p, k, i;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_TARGET;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    temperature_i    <= '0;
    elapsed_ms_i     <= '0;
    heating_enable_i <= 1'b0;
    restart_i        <= 1'b0;
    n_fail     = 0;
    rx_mode    = RX_FREE;
    hold_reqs  = 0;
    holds_done = 0;
    hold_left  = 0;
    rx_tick    = 0;

    // model state after reset
    cf_target = 6000;
    cf_max    = 8000;
    cf_rmin   = 1;
    cf_rmax   = 500;
    cf_elim   = 10;
    cf_sensor = 1'b1;
    pv_temp   = 0;
    pv_rate   = 0;
    pv_sum    = 0;
    pv_relay  = 1'b0;
    pv_band   = 1'b0;
    pv_fault  = 1'b0;
    pv_errs   = 10;
    pv_count  = '0;

    // Directed rows: {temp, elapsed, heat, restart}, typed, expected result
    dir_tbl[0]  = '{'{17'sd0, 16'd0, 1'b0, 1'b0}, 1'b1,
                    '{1'b0, 1'b0, 1'b0, 24'sd0, 8'd10, 32'sd0, 32'd0}};
    dir_tbl[1]  = '{'{17'sd0, 16'd65535, 1'b1, 1'b0}, 1'b1,
                    '{1'b1, 1'b0, 1'b0, 24'sd0, 8'd10, 32'sd0, 32'd0}};
    // hot sample: rate saturates high, over-temperature trips the latch
    dir_tbl[2]  = '{'{17'sd40000, 16'd0, 1'b1, 1'b0}, 1'b1,
                    '{1'b0, 1'b0, 1'b1, 24'sd8388607, 8'd10, 32'sd8388607, 32'd1}};
    // cold sample: rate saturates low, latch holds
    dir_tbl[3]  = '{'{-17'sd4000, 16'd0, 1'b1, 1'b0}, 1'b1,
                    '{1'b1, 1'b0, 1'b1, 24'h800000, 8'd10, -32'sd1, 32'd2}};
    // restart with heating off clears the latch only
    dir_tbl[4]  = '{'{17'sd0, 16'd0, 1'b0, 1'b1}, 1'b1,
                    '{1'b1, 1'b0, 1'b0, 24'h800000, 8'd10, -32'sd1, 32'd2}};
    dir_tbl[5]  = '{'{17'sd5900, 16'd999, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[6]  = '{'{17'sd5970, 16'd65535, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[7]  = '{'{17'sd5971, 16'd0, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[8]  = '{'{17'sd6029, 16'd999, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[9]  = '{'{17'sd6030, 16'd999, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[10] = '{'{17'sd6299, 16'd500, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[11] = '{'{17'sd6300, 16'd500, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[12] = '{'{17'sd8500, 16'd100, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[13] = '{'{17'sd8501, 16'd100, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[14] = '{'{17'sd5000, 16'd100, 1'b1, 1'b1}, 1'b0, '0};
    dir_tbl[15] = '{'{17'sd5100, 16'd0, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[16] = '{'{17'sd65535, 16'd0, 1'b0, 1'b0}, 1'b0, '0};
    dir_tbl[17] = '{'{17'sd65535, 16'd0, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[18] = '{'{17'h10000, 16'd0, 1'b1, 1'b0}, 1'b0, '0};
    dir_tbl[19] = '{'{-17'sd65535, 16'd65535, 1'b1, 1'b1}, 1'b0, '0};
    dir_tbl[20] = '{'{-17'sd65535, 16'd7, 1'b1, 1'b0}, 1'b0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed table
    for (i = 0; i < NumDirected; i++) begin
      send_sample(dir_tbl[i].smp, dir_tbl[i].typed, dir_tbl[i].want);
      idle_for($urandom_range(0, 2));
    end

    for (p = 0; p < NumPhases; p++) begin
      // reconfigure only once the block has drained
      if (p != 0) begin
        wait_idle();
        case (p)
          1: load_settings(40000, 40000, 0, 100000, 255, 1);
          2: load_settings(-4000, -4000, 100000, 0, 1, 0);
          3: load_settings(2000, 3000, 50, 200, 0, 1);
          default: begin
            tg  = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                              : longint'($urandom_range(0, 44000)) - 4000;
            mx  = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                              : tg + longint'($urandom_range(0, 4000)) - 1000;
            rmn = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                              : longint'($urandom_range(0, 300));
            rmx = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                              : rmn + longint'($urandom_range(0, 900));
            load_settings(tg, mx, rmn, rmx, longint'($urandom_range(0, 255)),
                          longint'($urandom_range(0, 3) != 0));
          end
        endcase
      end
      rx_mode    = rx_mode_e'(p % 4);
      ramp_t     = cf_target - longint'($urandom_range(0, 600));
      burst_left = $urandom_range(1, 24);

      for (k = 0; k < ItemsPerPhase; k++) begin
        if (p == HoldPhase && k == 20) hold_reqs++;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          // noise: every field random
          smp.temp    = TempW'($urandom);
          smp.elapsed = ElapW'($urandom);
          smp.heat    = 1'($urandom_range(0, 1));
          smp.restart = 1'($urandom_range(0, 1));
        end else begin
          // closed-loop ramp: rise while the relay is on, cool while off
          if (kind < 17)
            ramp_t = ramp_t + longint'($urandom_range(0, 4000)) - 2000;
          else if (pv_relay)
            ramp_t = ramp_t + longint'($urandom_range(0, 80));
          else
            ramp_t = ramp_t - longint'($urandom_range(0, 40));
          if (ramp_t > TempHi) ramp_t = TempHi;
          if (ramp_t < TempLo) ramp_t = TempLo;
          smp.temp = ramp_t[TempW-1:0];
          if (kind == 17)
            smp.elapsed = '0;
          else if (kind == 18)
            smp.elapsed = '1;
          else
            smp.elapsed = ElapW'($urandom_range(20, 1500));
          smp.heat    = (kind < 95);
          smp.restart = (kind >= 97) || (pv_fault && $urandom_range(0, 7) == 0);
        end
        send_sample(smp, 1'b0, '0);

        // bursts with random gaps
        burst_left--;
        if (burst_left == 0) begin
          g = $urandom_range(0, 99);
          if (g < 60)
            idle_for($urandom_range(1, 3));
          else if (g < 90)
            idle_for($urandom_range(4, 40));
          burst_left = $urandom_range(1, 24);
        end
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hhrg_pkg.sv
rtl/heater_hysteresis_with_rate_guard.sv
sim/tb.sv
